/* rtl/bkpq_pkg.sv */
package bkpq_pkg;

  // BUCKETS and BUCKET_DEPTH are powers of two
  localparam int unsigned BUCKETS      = 16;
  localparam int unsigned BUCKET_DEPTH = 64;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned VERTEX_BITS  = 20;

  localparam int unsigned FIFO_COUNT = 2 * BUCKETS;
  localparam int unsigned CAPACITY   = FIFO_COUNT * BUCKET_DEPTH;
  localparam int unsigned BKT_W      = $clog2(BUCKETS);
  localparam int unsigned Q_W        = BKT_W + 1;
  localparam int unsigned PTR_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int unsigned FILL_W     = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned ADDR_W     = Q_W + PTR_W;
  localparam int unsigned TOTAL_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W    = KEY_BITS + VERTEX_BITS;

  localparam int unsigned IN_DATA_W  = ((VERTEX_BITS + KEY_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((VERTEX_BITS + KEY_BITS + 7) / 8) * 8;

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

endpackage

/* rtl/bkpq_mem.sv */
module bkpq_mem
  import bkpq_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/two_level_bucket_priority_queue.sv */
// Two-level bucket priority queue for monotone (Dijkstra style) keys.
// Slave channel: tuser[1:0] is the mode (insert, extract minimum, clear),
// tdata carries vertex and key. Every request yields exactly one result on
// the master channel: tdata carries the extracted vertex and key (zero when
// nothing is extracted), tuser carries status and the now-empty flag.
// One request is in work at a time; tready is high only when the sequencer
// is idle, and it returns in the cycle after the result is registered.
// An insert passes through the insert state, then the result state; clear,
// the unused mode and extract on an empty queue go straight to the result
// state. An extract scans the bottom buckets in turn, skips empty ones,
// pops the first non-empty one and reads its entry; if all bottom buckets
// are empty it first examines top buckets in turn, moves the entries of the
// first non-empty one into bottom buckets (memory read, then write) and checks.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next request and then waits until the register is free.
// Reset clears all fill counts, read pointers and indices at once, so the
// queue is empty and ready the cycle after reset is released; the entry
// memory itself needs no clearing.
module two_level_bucket_priority_queue
  import bkpq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [19:0] vertex_id, [51:20] key_value, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [19:0] out_vertex, [51:20] out_key, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [1:0] status, [2] now_empty
  output logic [2:0]            m_axis_tuser_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_SCAN_BOT, S_SCAN_TOP, S_RD, S_WR, S_CHK, S_POP, S_POPD, S_RES
  } state_e;

  state_e                 state_q;
  logic [FILL_W-1:0]      fill_q [FIFO_COUNT];
  logic [PTR_W-1:0]       head_q [FIFO_COUNT];
  logic [BKT_W-1:0]       at_q;
  logic [BKT_W:0]         ab_q;
  logic [TOTAL_W-1:0]     total_q;
  logic [BKT_W-1:0]       cnt_q;
  logic [FILL_W-1:0]      n_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [VERTEX_BITS-1:0] vtx_q;
  logic [KEY_BITS-1:0]    res_key_q;
  logic [VERTEX_BITS-1:0] res_vtx_q;
  logic [1:0]             res_st_q;
  logic                   m_valid_q;
  logic [OUT_DATA_W-1:0]  m_data_q;
  logic [2:0]             m_user_q;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [ENTRY_W-1:0]     mem_wdata;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [ENTRY_W-1:0]     mem_rdata;

  logic [BKT_W-1:0]       ins_ti, ins_bi, mv_nb;
  logic [Q_W-1:0]         ins_q, mv_q, top_q, bot_q;
  logic [KEY_BITS-1:0]    mv_key;
  logic                   s_acc;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign ins_bi = key_q[BKT_W-1:0];
  assign ins_ti = key_q[2*BKT_W-1:BKT_W];
  assign ins_q  = (ins_ti == at_q && {1'b0, ins_bi} >= ab_q) ? {1'b1, ins_bi} : {1'b0, ins_ti};
  assign mv_key = mem_rdata[ENTRY_W-1:VERTEX_BITS];
  assign mv_nb  = mv_key[BKT_W-1:0];
  assign mv_q   = {1'b1, mv_nb};
  assign top_q  = {1'b0, at_q};
  assign bot_q  = {1'b1, ab_q[BKT_W-1:0]};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {ins_q, head_q[ins_q] + fill_q[ins_q][PTR_W-1:0]};
    mem_wdata = {key_q, vtx_q};
    mem_raddr = {bot_q, head_q[bot_q]};
    unique case (state_q)
      S_INS: begin
        mem_we = (fill_q[ins_q] < FILL_W'(BUCKET_DEPTH));
      end
      S_RD: begin
        mem_raddr = {top_q, head_q[top_q]};
      end
      S_WR: begin
        mem_we    = (fill_q[mv_q] < FILL_W'(BUCKET_DEPTH));
        mem_waddr = {mv_q, head_q[mv_q] + fill_q[mv_q][PTR_W-1:0]};
        mem_wdata = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  bkpq_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      for (int i = 0; i < FIFO_COUNT; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
      end
      at_q      <= '0;
      ab_q      <= '0;
      total_q   <= '0;
      cnt_q     <= '0;
      n_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // in S_RES the valid flag is set below instead
      if (m_valid_q && m_axis_tready_i && state_q != S_RES) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            key_q     <= s_axis_tdata_i[VERTEX_BITS +: KEY_BITS];
            vtx_q     <= s_axis_tdata_i[VERTEX_BITS-1:0];
            res_key_q <= '0;
            res_vtx_q <= '0;
            res_st_q  <= STAT_OK;
            cnt_q     <= '0;
            priority if (s_axis_tuser_i == MODE_INSERT) begin
              state_q <= S_INS;
            end else if (s_axis_tuser_i == MODE_EXTRACT) begin
              if (total_q == '0) begin
                res_st_q <= STAT_EMPTY;
                state_q  <= S_RES;
              end else begin
                state_q <= S_SCAN_BOT;
              end
            end else if (s_axis_tuser_i == MODE_CLEAR) begin
              for (int i = 0; i < FIFO_COUNT; i++) begin
                fill_q[i] <= '0;
                head_q[i] <= '0;
              end
              at_q    <= '0;
              ab_q    <= '0;
              total_q <= '0;
              state_q <= S_RES;
            end else begin
              state_q <= S_RES;
            end
          end
        end
        S_INS: begin
          if (fill_q[ins_q] < FILL_W'(BUCKET_DEPTH)) begin
            fill_q[ins_q] <= fill_q[ins_q] + 1'b1;
            total_q       <= total_q + 1'b1;
          end else begin
            res_st_q <= STAT_FULL;
          end
          state_q <= S_RES;
        end
        S_SCAN_BOT: begin
          if (ab_q[BKT_W]) begin
            state_q <= S_SCAN_TOP;
          end else if (fill_q[bot_q] != '0) begin
            state_q <= S_POP;
          end else begin
            ab_q <= ab_q + 1'b1;
          end
        end
        S_SCAN_TOP: begin
          if (fill_q[top_q] != '0) begin
            n_q     <= fill_q[top_q];
            ab_q    <= (BKT_W+1)'(BUCKETS);
            state_q <= S_RD;
          end else begin
            // full circle with nothing found leaves the top index at its start
            at_q  <= at_q + 1'b1;
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == BKT_W'(BUCKETS - 1)) begin
              res_st_q <= STAT_EMPTY;
              state_q  <= S_RES;
            end
          end
        end
        S_RD: begin
          head_q[top_q] <= head_q[top_q] + 1'b1;
          fill_q[top_q] <= fill_q[top_q] - 1'b1;
          n_q           <= n_q - 1'b1;
          state_q       <= S_WR;
        end
        S_WR: begin
          if ({1'b0, mv_nb} < ab_q) begin
            ab_q <= {1'b0, mv_nb};
          end
          if (fill_q[mv_q] < FILL_W'(BUCKET_DEPTH)) begin
            fill_q[mv_q] <= fill_q[mv_q] + 1'b1;
          end else if (total_q != '0) begin
            total_q <= total_q - 1'b1;
          end
          state_q <= (n_q == '0) ? S_CHK : S_RD;
        end
        S_CHK: begin
          if (!ab_q[BKT_W] && fill_q[bot_q] != '0) begin
            state_q <= S_POP;
          end else begin
            res_st_q <= STAT_EMPTY;
            state_q  <= S_RES;
          end
        end
        S_POP: begin
          head_q[bot_q] <= head_q[bot_q] + 1'b1;
          fill_q[bot_q] <= fill_q[bot_q] - 1'b1;
          total_q       <= total_q - 1'b1;
          state_q       <= S_POPD;
        end
        S_POPD: begin
          res_key_q <= mem_rdata[ENTRY_W-1:VERTEX_BITS];
          res_vtx_q <= mem_rdata[VERTEX_BITS-1:0];
          state_q   <= S_RES;
        end
        S_RES: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= OUT_DATA_W'({res_key_q, res_vtx_q});
            m_user_q  <= {total_q == '0, res_st_q};
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOTAL_W'(CAPACITY))
    else $error("entry count above capacity");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser_i == MODE_CLEAR) |=> (total_q == '0 && ab_q == '0))
    else $error("clear did not empty the queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (!ab_q[BKT_W] && fill_q[bot_q] != '0 && total_q != '0))
    else $error("pop from an empty bottom bucket");
  a_redist_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (fill_q[top_q] != '0))
    else $error("redistribution read from an empty top bucket");
`endif

endmodule
